// ----- rtl/u8e_pkg.sv -----
// Shared types, constants and helper functions for the UTF-8 decoder with escape.
`timescale 1ns / 1ps

package u8e_pkg;

  // Default depth of the byte queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Byte address of the escape_errors register.
  localparam logic [2:0] ADDR_ESCAPE_ERRORS = 3'd0;

  localparam logic [20:0] ESC_SIGN = 21'd9243;
  localparam logic [20:0] ESC_X    = 21'd120;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_VALUE     = 3'd3,
    ERR_LEAD      = 3'd4
  } err_kind_t;

  // A byte together with its classification.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] len;   // sequence length it leads, 0 when it is no valid lead
    logic       cont;  // it is a continuation byte
  } qbyte_t;

  // One queued item.
  typedef struct packed {
    qbyte_t b;
    logic   last;
  } item_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (!b[7]) begin
      n = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Lowercase ASCII hex digit as a code point.
  function automatic logic [20:0] hex_char(input logic [3:0] d);
    logic [20:0] base;
    base = (d < 4'd10) ? 21'd48 : 21'd87;
    return base + {17'd0, d};
  endfunction

endpackage

// ----- rtl/u8e_front.sv -----
// Front part: classifies incoming bytes and queues them for the back part.
`timescale 1ns / 1ps

module u8e_front #(
  parameter int unsigned QUEUE_DEPTH = u8e_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] data_byte
  input  logic            in_tlast,
  output logic            q_valid,
  input  logic            q_pop,
  output u8e_pkg::item_t  q_item
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  u8e_pkg::item_t   mem_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push, pop;
  u8e_pkg::item_t   new_item;

  assign in_tready = (count_r != QCW'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    new_item.b.data = in_tdata;
    new_item.b.len  = u8e_pkg::lead_len(in_tdata);
    new_item.b.cont = (in_tdata[7:6] == 2'b10);
    new_item.last   = in_tlast;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
  a_full_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QCW'(QUEUE_DEPTH)) |-> !in_tready)
    else $error("input ready while the queue is full");
`endif

endmodule

// ----- rtl/u8e_back.sv -----
// Back part: decodes buffered sequences; a byte is popped only once prior results are out.
`timescale 1ns / 1ps

module u8e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            escape_errors,
  input  logic            q_valid,
  output logic            q_pop,
  input  u8e_pkg::item_t  q_item,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [3:0]      out_tuser,  // [2:0] error_kind, [3] run_last
  output logic            out_tlast   // string_done
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_ESC    = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    ESC_EMIT_X  = 2'd0,
    ESC_EMIT_HI = 2'd1,
    ESC_EMIT_LO = 2'd2
  } esc_step_t;

  state_t               state_r, state_nxt;
  esc_step_t            esc_step_r, esc_step_nxt;
  u8e_pkg::qbyte_t      win_r [4];
  u8e_pkg::qbyte_t      win_nxt [4];
  u8e_pkg::qbyte_t      pend_r [3];
  u8e_pkg::qbyte_t      pend_nxt [3];
  logic [2:0]           rem_r, rem_nxt;
  logic                 end_r, end_nxt;
  logic [1:0]           pend_cnt_r, pend_cnt_nxt;
  logic                 drop_r, drop_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [20:0]          out_cp_r, out_cp_nxt;
  u8e_pkg::err_kind_t   out_kind_r, out_kind_nxt;
  logic                 out_run_last_r, out_run_last_nxt;
  logic                 out_done_r, out_done_nxt;

  logic [7:0]           b1;
  logic [2:0]           n;
  logic                 cont_ok;
  logic [20:0]          v2, v3, v4, value;
  u8e_pkg::err_kind_t   kind;
  logic                 need_more;
  logic [2:0]           cons;
  logic [2:0]           rem_a;
  u8e_pkg::qbyte_t      sh [4];
  logic                 more;
  logic                 out_free;

  // Decode of the sequence at the head of the window.
  assign b1 = win_r[0].data;
  assign n  = win_r[0].len;
  assign v2 = {10'd0, b1[4:0], win_r[1].data[5:0]};
  assign v3 = {5'd0, b1[3:0], win_r[1].data[5:0], win_r[2].data[5:0]};
  assign v4 = {b1[2:0], win_r[1].data[5:0], win_r[2].data[5:0], win_r[3].data[5:0]};

  always_comb begin
    case (n)
      3'd2:    cont_ok = win_r[1].cont;
      3'd3:    cont_ok = win_r[1].cont && win_r[2].cont;
      3'd4:    cont_ok = win_r[1].cont && win_r[2].cont && win_r[3].cont;
      default: cont_ok = 1'b1;
    endcase
  end

  always_comb begin
    kind  = u8e_pkg::ERR_NONE;
    value = {13'd0, b1};
    if (n == 3'd0) begin
      kind = u8e_pkg::ERR_LEAD;
    end else if (n == 3'd1) begin
      kind = u8e_pkg::ERR_NONE;
    end else if (rem_r < n) begin
      kind = u8e_pkg::ERR_TRUNCATED;
    end else if (!cont_ok) begin
      kind = u8e_pkg::ERR_BAD_CONT;
    end else begin
      case (n)
        3'd2: begin
          value = v2;
          if (v2 < 21'h80) kind = u8e_pkg::ERR_VALUE;
        end
        3'd3: begin
          value = v3;
          if (v3 < 21'h800 || (v3 >= 21'hD800 && v3 <= 21'hDFFF)) begin
            kind = u8e_pkg::ERR_VALUE;
          end
        end
        default: begin
          value = v4;
          if (v4 < 21'h10000) kind = u8e_pkg::ERR_VALUE;
        end
      endcase
    end
  end

  // An unfinished sequence at the head waits for more bytes of the string.
  assign need_more = !end_r && (n != 3'd0) && (rem_r < n);

  // Bytes consumed by the result now being produced, and the window after it.
  assign cons  = (state_r == ST_DECODE && kind == u8e_pkg::ERR_NONE) ? n : 3'd1;
  assign rem_a = rem_r - cons;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sh[i] = win_r[i];
    end
    case (cons)
      3'd1: begin
        sh[0] = win_r[1];
        sh[1] = win_r[2];
        sh[2] = win_r[3];
      end
      3'd2: begin
        sh[0] = win_r[2];
        sh[1] = win_r[3];
      end
      3'd3: begin
        sh[0] = win_r[3];
      end
      default: begin
        sh[0] = win_r[0];
      end
    endcase
  end

  // Another result follows unless the rest is empty or only waits for bytes.
  assign more = (rem_a != 3'd0) &&
                (end_r || (sh[0].len == 3'd0) || (rem_a >= sh[0].len));

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt        = state_r;
    esc_step_nxt     = esc_step_r;
    rem_nxt          = rem_r;
    end_nxt          = end_r;
    pend_cnt_nxt     = pend_cnt_r;
    drop_nxt         = drop_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_cp_nxt       = out_cp_r;
    out_kind_nxt     = out_kind_r;
    out_run_last_nxt = out_run_last_r;
    out_done_nxt     = out_done_r;
    q_pop            = 1'b0;
    for (int i = 0; i < 4; i++) begin
      win_nxt[i] = win_r[i];
    end
    for (int i = 0; i < 3; i++) begin
      pend_nxt[i] = pend_r[i];
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (drop_r) begin
            if (q_item.last) begin
              drop_nxt     = 1'b0;
              pend_cnt_nxt = 2'd0;
            end
          end else begin
            for (int i = 0; i < 3; i++) begin
              win_nxt[i] = (2'(i) < pend_cnt_r) ? pend_r[i] : q_item.b;
            end
            win_nxt[3]   = q_item.b;
            rem_nxt      = {1'b0, pend_cnt_r} + 3'd1;
            end_nxt      = q_item.last;
            pend_cnt_nxt = 2'd0;
            state_nxt    = ST_DECODE;
          end
        end
      end

      ST_DECODE: begin
        if (need_more) begin
          // Only reached on a freshly loaded window: the whole item is buffered.
          for (int i = 0; i < 3; i++) begin
            pend_nxt[i] = win_r[i];
          end
          pend_cnt_nxt = rem_r[1:0];
          state_nxt    = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if (kind == u8e_pkg::ERR_NONE) begin
            out_cp_nxt       = value;
            out_kind_nxt     = u8e_pkg::ERR_NONE;
            out_run_last_nxt = !more;
            out_done_nxt     = !more && end_r;
            for (int i = 0; i < 4; i++) begin
              win_nxt[i] = sh[i];
            end
            rem_nxt = rem_a;
            if (!more) begin
              state_nxt = ST_IDLE;
              for (int i = 0; i < 3; i++) begin
                pend_nxt[i] = sh[i];
              end
              pend_cnt_nxt = end_r ? 2'd0 : rem_a[1:0];
            end
          end else if (escape_errors) begin
            out_cp_nxt       = u8e_pkg::ESC_SIGN;
            out_kind_nxt     = u8e_pkg::ERR_NONE;
            out_run_last_nxt = 1'b0;
            out_done_nxt     = 1'b0;
            esc_step_nxt     = ESC_EMIT_X;
            state_nxt        = ST_ESC;
          end else begin
            out_cp_nxt       = '0;
            out_kind_nxt     = kind;
            out_run_last_nxt = 1'b1;
            out_done_nxt     = 1'b1;
            drop_nxt         = !end_r;
            pend_cnt_nxt     = 2'd0;
            state_nxt        = ST_IDLE;
          end
        end
      end

      ST_ESC: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = u8e_pkg::ERR_NONE;
          out_run_last_nxt = 1'b0;
          out_done_nxt     = 1'b0;
          case (esc_step_r)
            ESC_EMIT_X: begin
              out_cp_nxt   = u8e_pkg::ESC_X;
              esc_step_nxt = ESC_EMIT_HI;
            end
            ESC_EMIT_HI: begin
              out_cp_nxt   = u8e_pkg::hex_char(b1[7:4]);
              esc_step_nxt = ESC_EMIT_LO;
            end
            default: begin
              // Last escape character: the bad lead is dropped and decoding resumes.
              out_cp_nxt       = u8e_pkg::hex_char(b1[3:0]);
              out_run_last_nxt = !more;
              out_done_nxt     = !more && end_r;
              for (int i = 0; i < 4; i++) begin
                win_nxt[i] = sh[i];
              end
              rem_nxt = rem_a;
              if (more) begin
                state_nxt = ST_DECODE;
              end else begin
                state_nxt = ST_IDLE;
                for (int i = 0; i < 3; i++) begin
                  pend_nxt[i] = sh[i];
                end
                pend_cnt_nxt = end_r ? 2'd0 : rem_a[1:0];
              end
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_step_r  <= ESC_EMIT_X;
      pend_cnt_r  <= 2'd0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= 3'd0;
      end_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_step_r  <= esc_step_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      end_r       <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r          <= win_nxt;
    pend_r         <= pend_nxt;
    out_cp_r       <= out_cp_nxt;
    out_kind_r     <= out_kind_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_done_r     <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_cp_r};
  assign out_tuser  = {out_run_last_r, out_kind_r};
  assign out_tlast  = out_done_r;

`ifndef SYNTH
  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_run_last_r)
    else $error("string end flagged on a result that does not end its item");
  a_error_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != u8e_pkg::ERR_NONE) |-> out_done_r)
    else $error("error result that does not end the string");
  a_window_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECODE || state_r == ST_ESC) |-> (rem_r != 3'd0 && rem_r <= 3'd4))
    else $error("decoding with an empty or overfull window");
  a_drop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (state_r == ST_IDLE && pend_cnt_r == 2'd0))
    else $error("dropping while a sequence is being decoded");
`endif

endmodule

// ----- rtl/utf8_decoder_with_escape_top.sv -----
// An accepted byte passes through the queue, the window load of the back part and the
// output register before its first result shows. The back sequencer pops a byte from
// the queue and issues all of its results, up to sixteen, before it pops the next one.
// A queue, by default four deep, lets input run ahead while results drain or stall.
// Reset (synchronous, active low) empties the queue, the sequence buffer and the
// output register, clears the drop state and selects strict mode.
`timescale 1ns / 1ps

module utf8_decoder_with_escape_top #(
  parameter int unsigned QUEUE_DEPTH = u8e_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] code_point, [23:21] zero
  output logic [3:0]  out_tuser,   // [2:0] error_kind, [3] run_last
  output logic        out_tlast,   // string_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic           escape_errors_r, escape_errors_nxt;
  logic           cfg_hit;
  logic           q_valid, q_pop;
  u8e_pkg::item_t q_item;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == u8e_pkg::ADDR_ESCAPE_ERRORS[2]);
  assign cfg_prdata = cfg_hit ? {31'd0, escape_errors_r} : 32'd0;

  always_comb begin
    escape_errors_nxt = escape_errors_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      escape_errors_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_errors_r <= 1'b0;
    end else begin
      escape_errors_r <= escape_errors_nxt;
    end
  end

  u8e_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  u8e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .escape_errors(escape_errors_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the UTF-8 decoder with escape: directed and random strings.
`timescale 1ns / 1ps

module tb;

  localparam int          DRAIN_CYCLES = 40;
  localparam logic [2:0]  ADDR_UNUSED  = 3'd4;

  // Directed strings as {last, byte}.
  localparam logic [8:0] STRICT_BYTES [22] = '{
    9'h07F, 9'h0C2, 9'h080, 9'h0E0, 9'h0A0, 9'h080, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h100,
    9'h0E2, 9'h182,
    9'h0C3, 9'h041, 9'h142,
    9'h0C0, 9'h180,
    9'h0ED, 9'h0A0, 9'h180,
    9'h1FF
  };
  localparam logic [8:0] ESCAPE_BYTES [6] = '{
    9'h0FF, 9'h0E2, 9'h028, 9'h1A1, 9'h0F0, 9'h19F
  };

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [20:0]         cp;
    u8e_pkg::err_kind_t  kind;
    logic                run_last;
    logic                done;
  } cp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // [7:0] data_byte
  logic        in_tlast = 1'b0;     // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;           // [20:0] code_point, [23:21] zero
  logic [3:0]  out_tuser;           // [2:0] error_kind, [3] run_last
  logic        out_tlast;           // string_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  byte_item_t  stim_q [$];
  byte_item_t  next_item;
  cp_result_t  decoded_q [$];
  cp_result_t  want;
  logic [7:0]  str_buf [$];
  int          n_queued = 0;
  int          n_in_sent = 0;
  int          n_in_taken = 0;
  int          n_fail = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Predictor state.
  logic        esc_mode = 1'b0;
  logic [7:0]  held_bytes [3];
  int          held_count = 0;
  logic        skip_rest = 1'b0;

  utf8_decoder_with_escape_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the code points that one accepted byte releases.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]          seq [4];
    cp_result_t          res [16];
    logic [20:0]         v;
    logic [7:0]          b1;
    logic [3:0]          nib;
    u8e_pkg::err_kind_t  kind;
    int                  n_seq, pos, n, k, i, j;
    logic                strict_hit;
    if (skip_rest) begin
      if (last) begin
        skip_rest = 1'b0;
        held_count = 0;
      end
      return;
    end
    for (i = 0; i < held_count; i++) seq[i] = held_bytes[i];
    seq[held_count] = b;
    n_seq = held_count + 1;
    held_count = 0;
    pos = 0;
    k = 0;
    strict_hit = 1'b0;
    while (pos < n_seq && !strict_hit) begin
      b1 = seq[pos];
      kind = u8e_pkg::ERR_NONE;
      v = '0;
      casez (b1)
        8'b0???????: n = 1;
        8'b110?????: n = 2;
        8'b1110????: n = 3;
        8'b11110???: n = 4;
        default:     n = 0;
      endcase
      if (n == 1) begin
        res[k] = '{21'(b1), u8e_pkg::ERR_NONE, 1'b0, 1'b0};
        k++;
        pos++;
        continue;
      end
      if (n == 0) begin
        kind = u8e_pkg::ERR_LEAD;
      end else if (n_seq - pos < n) begin
        // An unfinished sequence waits for more bytes unless the string ends here.
        if (!last) begin
          for (i = 0; i < n_seq - pos; i++) held_bytes[i] = seq[pos + i];
          held_count = n_seq - pos;
          break;
        end
        kind = u8e_pkg::ERR_TRUNCATED;
      end else begin
        for (i = 1; i < n; i++) begin
          if (seq[pos + i][7:6] != 2'b10) kind = u8e_pkg::ERR_BAD_CONT;
        end
        if (kind == u8e_pkg::ERR_NONE) begin
          case (n)
            2: begin
              v = {10'd0, b1[4:0], seq[pos + 1][5:0]};
              if (v < 21'h80) kind = u8e_pkg::ERR_VALUE;
            end
            3: begin
              v = {5'd0, b1[3:0], seq[pos + 1][5:0], seq[pos + 2][5:0]};
              if (v < 21'h800 || (v >= 21'hD800 && v <= 21'hDFFF)) begin
                kind = u8e_pkg::ERR_VALUE;
              end
            end
            default: begin
              v = {b1[2:0], seq[pos + 1][5:0], seq[pos + 2][5:0], seq[pos + 3][5:0]};
              if (v < 21'h10000) kind = u8e_pkg::ERR_VALUE;
            end
          endcase
        end
      end
      if (kind == u8e_pkg::ERR_NONE) begin
        res[k] = '{v, u8e_pkg::ERR_NONE, 1'b0, 1'b0};
        k++;
        pos += n;
      end else if (esc_mode) begin
        // Only the lead byte is escaped; decoding restarts on the byte after it.
        res[k] = '{u8e_pkg::ESC_SIGN, u8e_pkg::ERR_NONE, 1'b0, 1'b0};
        res[k + 1] = '{u8e_pkg::ESC_X, u8e_pkg::ERR_NONE, 1'b0, 1'b0};
        for (j = 0; j < 2; j++) begin
          nib = (j == 0) ? b1[7:4] : b1[3:0];
          res[k + 2 + j] = '{21'(nib) + ((nib > 4'd9) ? 21'd87 : 21'd48),
                             u8e_pkg::ERR_NONE, 1'b0, 1'b0};
        end
        k += 4;
        pos++;
      end else begin
        res[k] = '{21'd0, kind, 1'b1, 1'b1};
        k++;
        skip_rest = !last;
        strict_hit = 1'b1;
      end
    end
    if (!strict_hit && k > 0) begin
      res[k - 1].run_last = 1'b1;
      res[k - 1].done = last;
    end
    if (last) held_count = 0;
    for (i = 0; i < k; i++) decoded_q.insert(decoded_q.size(), res[i]);
  endfunction

  function automatic void queue_byte(input logic [7:0] data, input logic last);
    byte_item_t item;
    item.last = last;
    item.data = data;
    stim_q.insert(stim_q.size(), item);
    n_queued++;
  endfunction

  function automatic void append_byte(input logic [7:0] b);
    str_buf.insert(str_buf.size(), b);
  endfunction

  function automatic void encode_cp(input logic [20:0] v, input int nb);
    case (nb)
      1: append_byte({1'b0, v[6:0]});
      2: begin
        append_byte({3'b110, v[10:6]});
        append_byte({2'b10, v[5:0]});
      end
      3: begin
        append_byte({4'b1110, v[15:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
      default: begin
        append_byte({5'b11110, v[20:18]});
        append_byte({2'b10, v[17:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] valid_cp(input int nb);
    logic [20:0] v;
    case (nb)
      2: v = 21'($urandom_range('h80, 'h7FF));
      3: begin
        v = 21'($urandom_range('h800, 'hFFFF));
        if (v >= 21'hD800 && v <= 21'hDFFF) v -= 21'h800;
      end
      default: begin
        v = 21'($urandom_range(0, 1) ? $urandom_range('h10000, 'h10FFFF)
                                     : $urandom_range('h10000, 'h1FFFFF));
      end
    endcase
    return v;
  endfunction

  // Most strings are well formed; a noisy one mixes in every kind of damage.
  task automatic add_random_string();
    int         n_chars, r, nb, i;
    logic       noisy;
    logic [7:0] junk;
    str_buf.delete();
    n_chars = $urandom_range(1, 6);
    noisy = ($urandom_range(0, 9) < 3);
    repeat (n_chars) begin
      r = noisy ? $urandom_range(0, 99) : $urandom_range(0, 65);
      nb = $urandom_range(2, 4);
      if (r < 30) begin
        encode_cp(21'($urandom_range(0, 127)), 1);
      end else if (r < 66) begin
        encode_cp(valid_cp(nb), nb);
      end else if (r < 71) begin
        encode_cp(21'($urandom_range(0, nb == 2 ? 'h7F : nb == 3 ? 'h7FF : 'hFFFF)), nb);
      end else if (r < 74) begin
        encode_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (r < 80) begin
        append_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                         : 8'($urandom_range('hF8, 'hFF)));
      end else if (r < 86) begin
        encode_cp(valid_cp(nb), nb);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        str_buf[str_buf.size() - 1 - $urandom_range(0, nb - 2)] = junk;
      end else if (r < 92) begin
        encode_cp(valid_cp(nb), nb);
        repeat ($urandom_range(1, nb - 1)) void'(str_buf.pop_back());
      end else begin
        append_byte(8'($urandom_range(0, 255)));
      end
    end
    for (i = 0; i < str_buf.size(); i++) queue_byte(str_buf[i], i == str_buf.size() - 1);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == u8e_pkg::ADDR_ESCAPE_ERRORS) esc_mode = data[0];
  endtask

  task automatic cfg_read_check(input logic [2:0] addr, input logic [31:0] expected);
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== expected) begin
      $error("escape_errors: expected %0h, actual %0h", expected, rd);
      n_fail++;
    end
  endtask

  // Waits until every queued byte is taken and every predicted result has come out.
  task automatic drain_results();
    while (stim_q.size() != 0 || n_in_taken != n_in_sent) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || n_in_taken == n_in_sent) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = stim_q.pop_front();
        in_tdata <= next_item.data;
        in_tlast <= next_item.last;
        in_tvalid <= 1'b1;
        n_in_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("code_point: expected nothing, actual %0h", out_tdata[20:0]);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata[20:0] !== want.cp) begin
            $error("code_point: expected %0h, actual %0h", want.cp, out_tdata[20:0]);
            n_fail++;
          end
          if (out_tuser[2:0] !== want.kind) begin
            $error("error_kind: expected %0d, actual %0d", want.kind, out_tuser[2:0]);
            n_fail++;
          end
          if (out_tuser[3] !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, out_tuser[3]);
            n_fail++;
          end
          if (out_tlast !== want.done) begin
            $error("string_done: expected %0b, actual %0b", want.done, out_tlast);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        n_in_taken++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int ph, goal;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'd0);
    cfg_read_check(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'd0);
    // A write past the last register must leave the mode alone.
    cfg_write(ADDR_UNUSED, 32'd1);
    cfg_read_check(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'd0);
    for (int i = 0; i < 22; i++) queue_byte(STRICT_BYTES[i][7:0], STRICT_BYTES[i][8]);
    drain_results();

    cfg_write(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'd1);
    cfg_read_check(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'd1);
    for (int i = 0; i < 6; i++) queue_byte(ESCAPE_BYTES[i][7:0], ESCAPE_BYTES[i][8]);
    drain_results();

    // Each phase pairs one mode with one idling pattern and ends fully drained.
    for (ph = 0; ph < 8; ph++) begin
      cfg_write(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'(ph % 2));
      cfg_read_check(u8e_pkg::ADDR_ESCAPE_ERRORS, 32'(ph % 2));
      case (ph / 2)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 23;
          recv_stall_pct = 23;
        end
      endcase
      goal = n_queued + 46;
      while (n_queued < goal) add_random_string();
      drain_results();
    end

    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- utf8_decoder_with_escape_top.f -----
rtl/u8e_pkg.sv
rtl/u8e_front.sv
rtl/u8e_back.sv
rtl/utf8_decoder_with_escape_top.sv
tb/sv/tb.sv
